[rtl/dbcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcp_pkg
// Shared types and character codes for the decimal byte command parser.
// ----------------------------------------------------------------------------
package dbcp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_VT    = 8'd11;
  localparam logic [7:0] CHAR_FF    = 8'd12;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // Largest byte value; the magnitude saturates one above it
  localparam logic [8:0] MAX_BYTE = 9'd255;
  localparam logic [8:0] MAG_SAT  = 9'd256;

  // Line phase: command token, then argument tokens
  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_ARG = 2'd1
  } phase_t;

  // Line status carried on the end-of-line word
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_CMD    = 3'd1,
    ST_CMD_RANGE = 3'd2,
    ST_ARG_NAN   = 3'd3,
    ST_ARG_RANGE = 3'd4
  } status_t;

  // One result word
  typedef struct packed {
    logic [7:0] value;
    logic       value_valid;
    logic       is_command_id;
    logic       end_of_line;
    status_t    status;
  } res_t;

endpackage

[rtl/dbcp_char_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcp_char_if
// Valid/ready channel carrying one character word.
// ----------------------------------------------------------------------------
interface dbcp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

[rtl/dbcp_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcp_res_if
// Valid/ready channel carrying one parsed token or end-of-line word.
// ----------------------------------------------------------------------------
interface dbcp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] value;
  logic       value_valid;
  logic       is_command_id;
  logic       end_of_line;
  logic [2:0] status;

  modport source (
    output valid, output value, output value_valid, output is_command_id,
    output end_of_line, output status, input ready
  );
  modport sink (
    input valid, input value, input value_valid, input is_command_id,
    input end_of_line, input status, output ready
  );
endinterface

[rtl/dbcp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcp_core
// Line and token state of the parser; one character per step strobe, with
// the result word and its emit flag formed in the same cycle.
// ----------------------------------------------------------------------------
module dbcp_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      char_byte,
  output logic            emit,
  output dbcp_pkg::res_t  res
);

  dbcp_pkg::phase_t  phase, phase_next;
  logic              in_token, in_token_next;
  logic              minus_seen, minus_seen_next;
  logic              digit_seen, digit_seen_next;
  logic [8:0]        magnitude, magnitude_next;
  dbcp_pkg::status_t line_error, line_error_next;

  // Character classes
  logic        is_nl, is_space, is_digit, is_minus, is_plus, out_of_range, no_error;
  logic [3:0]  digit;
  logic [11:0] mag_acc;
  logic [8:0]  mag_add;

  assign is_nl    = (char_byte == dbcp_pkg::CHAR_NL);
  assign is_space = (char_byte == dbcp_pkg::CHAR_SPACE) || (char_byte == dbcp_pkg::CHAR_TAB) ||
                    (char_byte == dbcp_pkg::CHAR_VT) || (char_byte == dbcp_pkg::CHAR_FF) ||
                    (char_byte == dbcp_pkg::CHAR_CR);
  assign is_digit = (char_byte >= dbcp_pkg::CHAR_ZERO) && (char_byte <= dbcp_pkg::CHAR_NINE);
  assign is_minus = (char_byte == dbcp_pkg::CHAR_MINUS);
  assign is_plus  = (char_byte == dbcp_pkg::CHAR_PLUS);
  assign digit    = 4'(char_byte - dbcp_pkg::CHAR_ZERO);
  assign no_error = (line_error == dbcp_pkg::ST_OK);

  // Accumulate one digit: magnitude * 10 + digit, saturating above a byte
  assign mag_acc = {magnitude, 3'b000} + {2'b00, magnitude, 1'b0} + {8'd0, digit};
  assign mag_add = (mag_acc > {3'd0, dbcp_pkg::MAX_BYTE}) ? dbcp_pkg::MAG_SAT : mag_acc[8:0];

  assign out_of_range = magnitude[8] || (minus_seen && (magnitude != 9'd0));

  // Next state
  always_comb begin
    phase_next      = phase;
    in_token_next   = in_token;
    minus_seen_next = minus_seen;
    digit_seen_next = digit_seen;
    magnitude_next  = magnitude;
    line_error_next = line_error;
    if (is_nl) begin
      phase_next      = dbcp_pkg::PH_CMD;
      in_token_next   = 1'b0;
      minus_seen_next = 1'b0;
      digit_seen_next = 1'b0;
      magnitude_next  = 9'd0;
      line_error_next = dbcp_pkg::ST_OK;
    end else if (no_error) begin
      case (phase)
        dbcp_pkg::PH_CMD: begin
          if (!in_token) begin
            if (is_plus || is_minus) begin
              in_token_next   = 1'b1;
              minus_seen_next = is_minus;
            end else if (is_digit) begin
              in_token_next   = 1'b1;
              magnitude_next  = mag_add;
              digit_seen_next = 1'b1;
            end else if (!is_space) begin
              line_error_next = dbcp_pkg::ST_NO_CMD;
            end
          end else if (is_digit) begin
            magnitude_next  = mag_add;
            digit_seen_next = 1'b1;
          end else if (!digit_seen) begin
            line_error_next = dbcp_pkg::ST_NO_CMD;
          end else if (out_of_range) begin
            line_error_next = dbcp_pkg::ST_CMD_RANGE;
          end else begin
            // Command done; the ending character may open the first argument
            phase_next      = dbcp_pkg::PH_ARG;
            in_token_next   = !is_space;
            minus_seen_next = is_minus;
            digit_seen_next = is_digit;
            magnitude_next  = is_digit ? {5'd0, digit} : 9'd0;
            if (!is_space && !is_minus && !is_digit) begin
              line_error_next = dbcp_pkg::ST_ARG_NAN;
            end
          end
        end
        dbcp_pkg::PH_ARG: begin
          if (!in_token) begin
            if (!is_space) begin
              in_token_next = 1'b1;
              if (is_minus) begin
                minus_seen_next = 1'b1;
              end else if (is_digit) begin
                magnitude_next  = mag_add;
                digit_seen_next = 1'b1;
              end else begin
                line_error_next = dbcp_pkg::ST_ARG_NAN;
              end
            end
          end else if (is_space) begin
            if (!digit_seen) begin
              line_error_next = dbcp_pkg::ST_ARG_NAN;
            end else if (out_of_range) begin
              line_error_next = dbcp_pkg::ST_ARG_RANGE;
            end else begin
              in_token_next   = 1'b0;
              minus_seen_next = 1'b0;
              digit_seen_next = 1'b0;
              magnitude_next  = 9'd0;
            end
          end else if (is_digit) begin
            magnitude_next  = mag_add;
            digit_seen_next = 1'b1;
          end else begin
            line_error_next = dbcp_pkg::ST_ARG_NAN;
          end
        end
        default: begin
          line_error_next = line_error;
        end
      endcase
    end
  end

  // Result word and emit flag
  always_comb begin
    emit = 1'b0;
    res  = '0;
    if (is_nl) begin
      emit            = 1'b1;
      res.end_of_line = 1'b1;
      res.status      = line_error;
      if (no_error) begin
        if (phase == dbcp_pkg::PH_CMD) begin
          if (in_token && digit_seen) begin
            if (out_of_range) begin
              res.status = dbcp_pkg::ST_CMD_RANGE;
            end else begin
              res.value         = magnitude[7:0];
              res.value_valid   = 1'b1;
              res.is_command_id = 1'b1;
            end
          end else begin
            res.status = dbcp_pkg::ST_NO_CMD;
          end
        end else if (in_token) begin
          if (!digit_seen) begin
            res.status = dbcp_pkg::ST_ARG_NAN;
          end else if (out_of_range) begin
            res.status = dbcp_pkg::ST_ARG_RANGE;
          end else begin
            res.value       = magnitude[7:0];
            res.value_valid = 1'b1;
          end
        end
      end
    end else if (no_error && in_token && digit_seen && !out_of_range) begin
      if ((phase == dbcp_pkg::PH_CMD) && !is_digit) begin
        emit              = 1'b1;
        res.value         = magnitude[7:0];
        res.value_valid   = 1'b1;
        res.is_command_id = 1'b1;
      end else if ((phase == dbcp_pkg::PH_ARG) && is_space) begin
        emit            = 1'b1;
        res.value       = magnitude[7:0];
        res.value_valid = 1'b1;
      end
    end
  end

  // Hold state unless a character is stepped through
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dbcp_pkg::PH_CMD;
      in_token   <= 1'b0;
      minus_seen <= 1'b0;
      digit_seen <= 1'b0;
      magnitude  <= 9'd0;
      line_error <= dbcp_pkg::ST_OK;
    end else if (step) begin
      phase      <= phase_next;
      in_token   <= in_token_next;
      minus_seen <= minus_seen_next;
      digit_seen <= digit_seen_next;
      magnitude  <= magnitude_next;
      line_error <= line_error_next;
    end
  end

endmodule

[rtl/decimal_byte_command_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_byte_command_parser
// Splits a character stream into lines of decimal tokens and emits one word
// per token that ends before the newline, plus one status word per line.
// ----------------------------------------------------------------------------
// Usage:
//   chars   : sink channel, one character word per handshake.
//   results : source channel, one word per token ended before the newline,
//             and one end_of_line word per newline, with the line status and any token it ends.
//   Other characters that finish no token produce no result word.
// Timing:
//   A character accepted into the input register is parsed combinationally
//   by the core; a word it causes is loaded into the result register when the
//   character is stepped, which waits while a held word is not taken.
//   Throughput is one character per cycle while results.ready is high, set by
//   the token state and the x10 adder updating together on each step.
// Reset:
//   rst (synchronous) empties both registers and returns the parser to the
//   start of a line with no token and no error.
// Backpressure:
//   While a word waits with results.ready low, the result register holds it
//   and the held character waits in the input register; chars.ready stays
//   high only while the input register is empty, so at most one more
//   character is taken before chars.ready drops.
// ----------------------------------------------------------------------------
module decimal_byte_command_parser (
  input  logic               clk,
  input  logic               rst,
  dbcp_char_if.sink          chars,
  dbcp_res_if.source         results
);

  logic           s1_valid;
  logic [7:0]     s1_char;
  logic           advance;
  logic           emit;
  dbcp_pkg::res_t step_res;
  logic           out_valid;
  dbcp_pkg::res_t out_res;

  // Step the held character when the result register can take its word
  assign advance     = s1_valid && (!out_valid || results.ready);
  assign chars.ready = !s1_valid || advance;

  dbcp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_byte (s1_char),
    .emit      (emit),
    .res       (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      s1_char <= chars.char_byte;
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res <= step_res;
    end
  end

  assign results.valid         = out_valid;
  assign results.value         = out_res.value;
  assign results.value_valid   = out_res.value_valid;
  assign results.is_command_id = out_res.is_command_id;
  assign results.end_of_line   = out_res.end_of_line;
  assign results.status        = out_res.status;

`ifndef SYNTHESIS
  // Token words never carry a status
  a_token_status_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.end_of_line) |-> (out_res.status == dbcp_pkg::ST_OK))
    else $error("token word with nonzero status");

  // Token words always carry a value
  a_token_has_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.end_of_line) |-> out_res.value_valid)
    else $error("token word without value");

  // No value and no command flag unless the value is good
  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.value_valid) |->
      ((out_res.value == 8'd0) && !out_res.is_command_id))
    else $error("stray value on word without token");

  // A good value on any word means its status is ok
  a_eol_value_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.value_valid) |-> (out_res.status == dbcp_pkg::ST_OK))
    else $error("value reported on failed line");
`endif

endmodule
